>>> src/i2cm_pkg.sv
// Package with the types and constants shared by the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the kind field of an input item.
    typedef enum logic [2:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_SEND      = 3'd2,
        CMD_RECV      = 3'd3,
        CMD_ACK       = 3'd4,
        CMD_NACK      = 3'd5,
        CMD_WAIT_ACK  = 3'd6,
        CMD_WAIT_NACK = 3'd7
    } t_cmd;

    // Configuration register indexes.
    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_ACK_RETRIES = 1'b1;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd20;
    localparam logic [7:0]  ACK_RETRIES_RST = 8'd5;

    // One input item: one timing tick.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] kind;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_in_item;

    // One result item: line levels and status after the tick.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_error;
    } t_out_item;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  ack_retries;
    } t_cfg;

    // Engine state carried from one tick to the next.
    typedef struct packed {
        t_cmd        active_command;
        logic        running;
        logic [3:0]  phase_step;
        logic [15:0] hold_count;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [7:0]  retry_count;
        logic        scl_level;
        logic        sda_level;
        logic        error_flag;
        logic        sda_released;
    } t_eng_state;

    localparam t_eng_state ENG_STATE_RST = '{
        active_command: CMD_START,
        running:        1'b0,
        phase_step:     4'd0,
        hold_count:     16'd0,
        bit_count:      4'd0,
        shift_reg:      8'd0,
        retry_count:    8'd0,
        scl_level:      1'b1,
        sda_level:      1'b1,
        error_flag:     1'b0,
        sda_released:   1'b0
    };

endpackage

`default_nettype wire

>>> src/i2cm_cfg.sv
// APB configuration registers of the I2C master bit engine.
`default_nettype none

module i2cm_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic      [31:0]    prdata,
    output logic                pready,
    output i2cm_pkg::t_cfg      o_cfg
);

    i2cm_pkg::t_cfg r_cfg;
    i2cm_pkg::t_cfg n_cfg;
    logic           w_wr;
    logic           w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                i2cm_pkg::REG_PHASE_TICKS: n_cfg.phase_ticks = pwdata[15:0];
                i2cm_pkg::REG_ACK_RETRIES: n_cfg.ack_retries = pwdata[7:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
            r_cfg.ack_retries <= i2cm_pkg::ACK_RETRIES_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            i2cm_pkg::REG_PHASE_TICKS: prdata = {16'd0, r_cfg.phase_ticks};
            i2cm_pkg::REG_ACK_RETRIES: prdata = {24'd0, r_cfg.ack_retries};
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/i2cm_step.sv
// Next-state and result logic for one tick of the I2C master bit engine.
`default_nettype none

module i2cm_step (
    input  wire i2cm_pkg::t_eng_state i_state,
    input  wire i2cm_pkg::t_in_item   i_item,
    input  wire i2cm_pkg::t_cfg       i_cfg,
    output i2cm_pkg::t_eng_state      o_state,
    output i2cm_pkg::t_out_item       o_result
);

    i2cm_pkg::t_eng_state base;
    i2cm_pkg::t_eng_state nxt;
    logic                 fin;
    logic                 want;
    logic                 do_check;
    logic [15:0]          hold_reload;
    logic [7:0]           retry_init;

    assign hold_reload = (i_cfg.phase_ticks == 16'd0) ? 16'd0 : i_cfg.phase_ticks - 16'd1;
    assign retry_init  = (i_cfg.ack_retries == 8'd0) ? 8'd1 : i_cfg.ack_retries;

    always_comb begin
        base     = i_state;
        nxt      = i_state;
        fin      = 1'b0;
        want     = 1'b0;
        do_check = 1'b0;

        // An idle engine loads a new command; its first step runs on this tick.
        if (!i_state.running) begin
            base.active_command = i2cm_pkg::t_cmd'(i_item.kind);
            base.running        = 1'b1;
            base.phase_step     = 4'd0;
            base.bit_count      = 4'd0;
            base.error_flag     = 1'b0;
            base.shift_reg      = (i2cm_pkg::t_cmd'(i_item.kind) == i2cm_pkg::CMD_SEND) ?
                                  i_item.tx_byte : 8'd0;
        end

        if (i_state.running && (i_state.hold_count != 16'd0)) begin
            nxt.hold_count = i_state.hold_count - 16'd1;
        end else if (i_state.running || i_item.cmd_valid) begin
            nxt = base;
            case (base.active_command)
                i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: begin
                    if (base.phase_step >= 4'd4) begin
                        fin = 1'b1;
                    end else begin
                        if (base.active_command == i2cm_pkg::CMD_START) begin
                            case (base.phase_step)
                                4'd0:    nxt.sda_level = 1'b1;
                                4'd1:    nxt.scl_level = 1'b1;
                                4'd2:    nxt.sda_level = 1'b0;
                                default: nxt.scl_level = 1'b0;
                            endcase
                        end else begin
                            case (base.phase_step)
                                4'd0:    nxt.scl_level = 1'b0;
                                4'd1:    nxt.sda_level = 1'b0;
                                4'd2:    nxt.scl_level = 1'b1;
                                default: nxt.sda_level = 1'b1;
                            endcase
                        end
                        nxt.sda_released = 1'b0;
                        nxt.phase_step   = base.phase_step + 4'd1;
                    end
                end
                i2cm_pkg::CMD_SEND: begin
                    case (base.phase_step)
                        4'd0: begin
                            nxt.scl_level  = 1'b0;
                            nxt.phase_step = 4'd1;
                        end
                        4'd1: begin
                            nxt.sda_level  = base.shift_reg[7];
                            nxt.phase_step = 4'd2;
                        end
                        4'd2: begin
                            nxt.shift_reg  = {base.shift_reg[6:0], 1'b0};
                            nxt.phase_step = 4'd3;
                        end
                        4'd3: begin
                            nxt.scl_level  = 1'b1;
                            nxt.bit_count  = base.bit_count + 4'd1;
                            nxt.phase_step = (nxt.bit_count < 4'd8) ? 4'd0 : 4'd4;
                        end
                        4'd4: begin
                            nxt.scl_level  = 1'b0;
                            nxt.phase_step = 4'd5;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                i2cm_pkg::CMD_RECV: begin
                    case (base.phase_step)
                        4'd0: begin
                            nxt.sda_released = 1'b1;
                            nxt.scl_level    = 1'b0;
                            nxt.phase_step   = 4'd1;
                        end
                        4'd1: nxt.phase_step = 4'd2;
                        4'd2: begin
                            nxt.scl_level  = 1'b1;
                            nxt.phase_step = 4'd3;
                        end
                        4'd3: begin
                            nxt.shift_reg  = {base.shift_reg[6:0], i_item.sda_in};
                            nxt.bit_count  = base.bit_count + 4'd1;
                            nxt.scl_level  = 1'b0;
                            nxt.phase_step = (nxt.bit_count < 4'd8) ? 4'd1 : 4'd4;
                        end
                        default: begin
                            nxt.sda_released = 1'b0;
                            fin              = 1'b1;
                        end
                    endcase
                end
                i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK: begin
                    if (base.phase_step >= 4'd4) begin
                        fin = 1'b1;
                    end else begin
                        case (base.phase_step)
                            4'd0: begin
                                nxt.sda_level    = (base.active_command == i2cm_pkg::CMD_NACK);
                                nxt.sda_released = 1'b0;
                            end
                            4'd2:    nxt.scl_level = 1'b1;
                            4'd3:    nxt.scl_level = 1'b0;
                            default: nxt.scl_level = base.scl_level;
                        endcase
                        nxt.phase_step = base.phase_step + 4'd1;
                    end
                end
                default: begin
                    // Wait for acknowledge or for not-acknowledge.
                    want = (base.active_command == i2cm_pkg::CMD_WAIT_NACK);
                    if (base.phase_step >= 4'd5) begin
                        fin = 1'b1;
                    end else if (base.phase_step == 4'd0) begin
                        nxt.retry_count  = retry_init;
                        nxt.sda_released = 1'b1;
                        nxt.phase_step   = 4'd1;
                    end else if (base.phase_step == 4'd1) begin
                        nxt.scl_level  = 1'b1;
                        nxt.phase_step = 4'd2;
                    end else if ((base.phase_step == 4'd2) || (base.retry_count != 8'd0)) begin
                        do_check = 1'b1;
                    end else begin
                        // Timed out: flag the error and finish with a stop sequence.
                        nxt.error_flag     = 1'b1;
                        nxt.sda_released   = 1'b0;
                        nxt.active_command = i2cm_pkg::CMD_STOP;
                        nxt.scl_level      = 1'b0;
                        nxt.phase_step     = 4'd1;
                    end
                    if (do_check) begin
                        if (i_item.sda_in == want) begin
                            nxt.sda_released = 1'b0;
                            nxt.scl_level    = 1'b0;
                            nxt.phase_step   = 4'd5;
                        end else begin
                            nxt.retry_count = base.retry_count - 8'd1;
                            nxt.phase_step  = 4'd3;
                        end
                    end
                end
            endcase
            if (fin) begin
                nxt.running = 1'b0;
            end else begin
                nxt.hold_count = hold_reload;
            end
        end
    end

    assign o_state = nxt;

    always_comb begin
        o_result.scl_out   = nxt.scl_level;
        o_result.sda_out   = nxt.sda_released ? 1'b1 : nxt.sda_level;
        o_result.sda_drive = !nxt.sda_released;
        o_result.busy_res  = nxt.running;
        o_result.done_res  = fin;
        o_result.rx_byte   = (fin && (nxt.active_command == i2cm_pkg::CMD_RECV)) ?
                             nxt.shift_reg : 8'd0;
        o_result.ack_error = fin && nxt.error_flag;
    end

endmodule

`default_nettype wire

>>> src/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: tick register, engine state and result register.
`default_nettype none

// I2C master line engine. Every input item is one timing tick that may carry
// a command (start, stop, send byte, receive byte, send ack or nack, wait for
// ack or nack) together with the sampled SDA level; every tick yields exactly
// one result item with the driven SCL and SDA levels, the SDA drive enable,
// and the busy, done, received-byte and ack-error status. Each line change is
// held for phase_ticks ticks (zero counts as one), and an acknowledge wait
// gives up after ack_retries holds (zero counts as one), runs a stop
// sequence and reports an error on its done tick. Commands offered while busy
// are ignored. The engine takes one tick per clock cycle when the result side
// does not stall: a tick is registered at the input, and the next-state logic
// then updates the engine state and fills the result register, from which the
// result is offered. A stall on the result side holds the result register
// and backs up into the input register, which then stalls the input side.
// The two configuration registers sit on an APB port at byte addresses 0
// (phase_ticks) and 4 (ack_retries) and should be written only while the
// engine is idle.

module i2c_master_bit_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire i2cm_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output i2cm_pkg::t_out_item      o_out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready
);

    i2cm_pkg::t_cfg       w_cfg;
    i2cm_pkg::t_eng_state r_state;
    i2cm_pkg::t_eng_state w_state_nxt;
    i2cm_pkg::t_out_item  w_result;

    logic                 r_in_valid;
    logic                 n_in_valid;
    i2cm_pkg::t_in_item   r_in_item;
    logic                 r_out_valid;
    logic                 n_out_valid;
    i2cm_pkg::t_out_item  r_out_item;

    logic                 w_accept;
    logic                 w_fire;

    i2cm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    i2cm_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_state  (w_state_nxt),
        .o_result (w_result)
    );

    // The registered tick is processed when the result register is free or
    // its current item leaves on this edge.
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= i2cm_pkg::ENG_STATE_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_fire) begin
                r_state <= w_state_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
